/* rtl/flci_pkg.sv */
// Package: shared constants, types and helpers of the coalescing free-segment table.
`default_nettype none
package flci_pkg;

  localparam int ENTRIES      = 32;
  localparam int ADDRESS_BITS = 32;
  localparam int SIZE_W       = ADDRESS_BITS + 1;
  localparam int ADDR_W       = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_ALONE = 3'd0,
    ST_NEXT  = 3'd1,
    ST_PREV  = 3'd2,
    ST_BOTH  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SUM1,
    S_SUM2,
    S_WRITE,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] start;
    logic [SIZE_W-1:0]       size;
  } seg_t;

  typedef struct packed {
    logic load;
    logic search_en;
    logic decide;
    logic sum1;
    logic sum2;
    logic write_en;
    logic shift_init;
    logic shift_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic search_done;
    logic join_next;
    logic join_prev;
    logic full;
    logic shift_done;
  } stat_t;

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/flci_ctrl.sv */
// Controller: sequences search, merge decision, size sums, table writes and shifts.
`default_nettype none
module flci_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire flci_pkg::stat_t st,
  output flci_pkg::cmd_t      cmd,
  output logic                busy
);

  flci_pkg::state_t state, state_next;
  logic both;

  assign both = st.join_next && st.join_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flci_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      flci_pkg::S_IDLE: begin
        if (start) begin
          state_next = st.count_zero ? flci_pkg::S_DECIDE : flci_pkg::S_SEARCH;
        end
      end
      flci_pkg::S_SEARCH: begin
        if (st.search_done) begin
          state_next = flci_pkg::S_DECIDE;
        end
      end
      flci_pkg::S_DECIDE: state_next = flci_pkg::S_SUM1;
      flci_pkg::S_SUM1: begin
        priority if (both) begin
          state_next = flci_pkg::S_SUM2;
        end else if (st.join_next || st.join_prev) begin
          state_next = flci_pkg::S_WRITE;
        end else if (st.full) begin
          state_next = flci_pkg::S_DONE;
        end else begin
          state_next = flci_pkg::S_SHIFT;
        end
      end
      flci_pkg::S_SUM2: state_next = flci_pkg::S_WRITE;
      flci_pkg::S_WRITE: state_next = both ? flci_pkg::S_SHIFT : flci_pkg::S_DONE;
      flci_pkg::S_SHIFT: begin
        if (st.shift_done) begin
          state_next = both ? flci_pkg::S_DONE : flci_pkg::S_WRITE;
        end
      end
      flci_pkg::S_DONE: state_next = flci_pkg::S_IDLE;
      default: state_next = flci_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == flci_pkg::S_IDLE) && start;
    cmd.search_en  = (state == flci_pkg::S_SEARCH);
    cmd.decide     = (state == flci_pkg::S_DECIDE);
    cmd.sum1       = (state == flci_pkg::S_SUM1);
    cmd.sum2       = (state == flci_pkg::S_SUM2);
    cmd.write_en   = (state == flci_pkg::S_WRITE);
    cmd.shift_init = ((state == flci_pkg::S_SUM1) && !st.join_next && !st.join_prev)
                  || ((state == flci_pkg::S_WRITE) && both);
    cmd.shift_en   = (state == flci_pkg::S_SHIFT);
    cmd.finish     = (state == flci_pkg::S_DONE);
    busy           = (state != flci_pkg::S_IDLE);
  end

endmodule
`default_nettype wire

/* rtl/flci_dp.sv */
// Datapath: segment table memory, search pointer, merge arithmetic and result registers.
`default_nettype none
module flci_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire flci_pkg::cmd_t                      cmd,
  output flci_pkg::stat_t                          st,
  input  wire logic [flci_pkg::ADDRESS_BITS-1:0]   block_start,
  input  wire logic [flci_pkg::ADDRESS_BITS-1:0]   block_size,
  output logic                                     done,
  output logic [2:0]                               status,
  output logic [flci_pkg::ADDR_W-1:0]              segment_index,
  output logic [flci_pkg::ADDRESS_BITS-1:0]        segment_start,
  output logic [flci_pkg::SIZE_W-1:0]              segment_size,
  output logic [flci_pkg::CNT_W-1:0]               segment_count
);

  localparam int AW = flci_pkg::ADDR_W;
  localparam int CW = flci_pkg::CNT_W;
  localparam int SW = flci_pkg::SIZE_W;
  localparam int BW = flci_pkg::ADDRESS_BITS;

  flci_pkg::seg_t mem [flci_pkg::ENTRIES];
  flci_pkg::seg_t rdata, prev, nxt, wseg, wdata;

  logic [BW-1:0] bstart, bsize;
  logic [BW:0]   bend;
  logic [CW-1:0] count, pos, k, pos_inc, k_step;
  logic [AW-1:0] raddr, waddr, widx, wtag;
  logic [SW-1:0] acc;
  logic          rvalid, nfound, jn, jp, full, le, more, up, we, rejected;

  assign up       = !(jn && jp);
  assign le       = rdata.start <= bstart;
  assign pos_inc  = pos + CW'(1);
  assign k_step   = up ? (k - CW'(1)) : (k + CW'(1));
  assign more     = up ? (k != pos) : (({1'b0, k} + (CW+1)'(1)) < {1'b0, count});
  assign rejected = full && !jn && !jp;

  assign widx = jp ? (pos[AW-1:0] - AW'(1)) : pos[AW-1:0];

  always_comb begin
    wseg.start = jp ? prev.start : bstart;
    wseg.size  = (jn || jp) ? acc : {1'b0, bsize};
  end

  always_comb begin
    raddr = '0;
    if (cmd.search_en) begin
      raddr = rvalid ? pos_inc[AW-1:0] : pos[AW-1:0];
    end else if (cmd.shift_en) begin
      raddr = k_step[AW-1:0];
    end
    we    = cmd.write_en || (cmd.shift_en && rvalid);
    waddr = cmd.write_en ? widx : wtag;
    wdata = cmd.write_en ? wseg : rdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    st.count_zero  = (count == '0);
    st.search_done = rvalid && (!le || (pos_inc == count));
    st.join_next   = jn;
    st.join_prev   = jp;
    st.full        = full;
    st.shift_done  = !more && !rvalid;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bstart <= block_start;
      bsize  <= block_size;
      bend   <= {1'b0, block_start} + {1'b0, block_size};
      pos    <= '0;
      rvalid <= 1'b0;
      nfound <= 1'b0;
    end
    if (cmd.search_en) begin
      rvalid <= 1'b1;
      if (rvalid) begin
        if (le) begin
          prev <= rdata;
          pos  <= pos_inc;
        end else begin
          nxt    <= rdata;
          nfound <= 1'b1;
        end
      end
    end
    if (cmd.decide) begin
      jn   <= nfound && (bend == {1'b0, nxt.start});
      jp   <= (pos != '0) &&
              (({2'b0, prev.start} + {1'b0, prev.size}) == {2'b0, bstart});
      full <= (count == CW'(flci_pkg::ENTRIES));
    end
    if (cmd.sum1) begin
      acc <= flci_pkg::sat_add(jp ? prev.size : {1'b0, bsize},
                               jp ? {1'b0, bsize} : nxt.size);
    end
    if (cmd.sum2) begin
      acc <= flci_pkg::sat_add(acc, nxt.size);
    end
    if (cmd.shift_init) begin
      k      <= (jn && jp) ? pos : count;
      rvalid <= 1'b0;
    end
    if (cmd.shift_en) begin
      if (more) begin
        wtag   <= k[AW-1:0];
        k      <= k_step;
        rvalid <= 1'b1;
      end else begin
        rvalid <= 1'b0;
      end
    end
    if (cmd.finish) begin
      priority if (rejected) begin
        status <= flci_pkg::ST_FULL;
      end else if (jn && jp) begin
        status <= flci_pkg::ST_BOTH;
      end else if (jp) begin
        status <= flci_pkg::ST_PREV;
      end else if (jn) begin
        status <= flci_pkg::ST_NEXT;
      end else begin
        status <= flci_pkg::ST_ALONE;
      end
      segment_index <= rejected ? '0 : widx;
      segment_start <= wseg.start;
      segment_size  <= wseg.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        priority if (jn && jp) begin
          count <= count - CW'(1);
        end else if (!jn && !jp && !full) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  assign segment_count = count;

endmodule
`default_nettype wire

/* rtl/free_list_coalescing_insert.sv */
// Top level: address-ordered free-segment table with coalescing on insert.
//
// Usage: drive block_start/block_size and pulse start while busy is low; the
// item is taken at that clock edge and busy rises. One result follows per
// item: done is high for exactly one cycle with status, segment_index,
// segment_start, segment_size and segment_count valid in that cycle. The
// receiver cannot stall; busy is already low while done is shown, so a new
// item may be started in the same cycle.
// Steps of an item:
//   search   one entry read per cycle after a priming read, until a higher
//            segment ends it or it runs off the end; none on an empty table
//   decide and size sums   a second sum only for a double merge
//   shift    entries moved to open or close a gap (plain inserts
//            and double merges only)
//   write, finish   (finish only for a rejected item), then done
// Reset empties the table (count to zero) at once; no
// clearing pass is needed since only entries below the count are read.
`default_nettype none
module free_list_coalescing_insert (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [flci_pkg::ADDRESS_BITS-1:0]   block_start,
  input  wire logic [flci_pkg::ADDRESS_BITS-1:0]   block_size,
  output logic                                     done,
  output logic [2:0]                               status,
  output logic [flci_pkg::ADDR_W-1:0]              segment_index,
  output logic [flci_pkg::ADDRESS_BITS-1:0]        segment_start,
  output logic [flci_pkg::SIZE_W-1:0]              segment_size,
  output logic [flci_pkg::CNT_W-1:0]               segment_count
);

  flci_pkg::cmd_t  cmd;
  flci_pkg::stat_t st;

  flci_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  flci_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .block_start   (block_start),
    .block_size    (block_size),
    .done          (done),
    .status        (status),
    .segment_index (segment_index),
    .segment_start (segment_start),
    .segment_size  (segment_size),
    .segment_count (segment_count)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == 3'(flci_pkg::ST_FULL)))
      |-> (segment_count == flci_pkg::CNT_W'(flci_pkg::ENTRIES)))
    else $error("rejection reported while table not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (segment_count <= flci_pkg::CNT_W'(flci_pkg::ENTRIES)))
    else $error("segment count beyond table depth");

endmodule
`default_nettype wire
